// ===== design/hprc_pkg.sv =====
// hprc_pkg: shared types and constants for the HID pointer report converter.
// Holds the report command passed from the front end to the back end and
// the result layout; no dependencies.
package hprc_pkg;

  localparam int HPRC_QDEPTH  = 2;
  localparam int HPRC_QPTR_W  = (HPRC_QDEPTH > 1) ? $clog2(HPRC_QDEPTH) : 1;
  localparam int HPRC_QCNT_W  = $clog2(HPRC_QDEPTH + 1);

  localparam int HPRC_HELD    = 7;
  localparam logic [4:0] HPRC_CNT_MAX    = 5'd31;
  localparam logic [4:0] HPRC_LEN_MOUSE  = 5'd7;
  localparam logic [4:0] HPRC_LEN_PAD    = 5'd19;
  localparam logic [4:0] HPRC_LEN_SMIN   = 5'd4;

  localparam logic [6:0] HPRC_CONTACT_ONE = 7'd1;
  localparam logic [6:0] HPRC_CONTACT_TWO = 7'd2;
  localparam logic [6:0] HPRC_CONTACT_NONE = 7'd0;

  localparam logic signed [12:0] HPRC_JUMP_HI = 13'sd150;
  localparam logic signed [12:0] HPRC_JUMP_LO = -13'sd150;

  localparam int HPRC_DIV_STEPS = 8;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MOUSE,
    KIND_SIMPLE,
    KIND_PAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] last;        // final byte of the report
    logic [6:0][7:0] b;      // first seven report bytes
  } cmd_t;

  typedef struct packed {
    logic [7:0]  wheel_horizontal;
    logic [7:0]  wheel_vertical;
    logic [11:0] delta_y;
    logic [11:0] delta_x;
    logic [7:0]  button_bits;
  } res_t;

endpackage

// ===== design/hid_pointer_report_converter_core.sv =====
// hid_pointer_report_converter_core: top level of the HID report converter.
// Depends on hprc_pkg, hprc_front, hprc_fifo and hprc_back.
//
// Usage: report bytes enter on the s_ group, one byte per transfer, with
// s_tlast on the final byte of a report. When a report ends it is classed by
// length: 7 bytes full mouse, 4 to 6 bytes simple mouse, 19 bytes trackpad,
// anything else dropped. Results leave on the m_ group, up to two per
// report; m_tlast marks the last result of a report.
// A mouse report's result passes through the command queue, a result holding
// register and the output register. A trackpad report that moves the pointer
// also runs the 8-step bit-serial divide of the motion deltas; others skip it.
// The front end takes a byte every cycle while the two-entry command queue
// has room, so bytes keep flowing while the back end divides or while a
// result waits in the output register. When m_tready stays low the queue
// fills and s_tready drops.
// cfg_we writes move_divisor (0 acts as 1); write it only while idle.
// rst (synchronous) empties the queue, clears the byte count and all
// trackpad tracking, and sets move_divisor to 1.
module hid_pointer_report_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] report_byte
  input  logic        s_tlast,   // end_of_report
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] button_bits, [19:8] delta_x, [31:20] delta_y,
                                 // [39:32] wheel_vertical, [47:40] wheel_horizontal
  output logic        m_tlast,   // final_of_run
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  logic           push, q_full, q_not_empty, pop;
  hprc_pkg::cmd_t push_data, pop_data;
  hprc_pkg::res_t out_res;
  logic [4:0]     move_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_divisor <= 5'd1;
    end else if (cfg_we) begin
      move_divisor <= cfg_wdata;
    end
  end

  hprc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_end    (s_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  hprc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  hprc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .move_divisor (move_divisor),
    .cmd_valid    (q_not_empty),
    .cmd          (pop_data),
    .cmd_pop      (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_res      (out_res),
    .out_last     (m_tlast)
  );

  assign m_tdata = out_res;

endmodule

// ===== design/hprc_front.sv =====
// hprc_front: collects report bytes, counts them and classifies each
// finished report by length into a command for the queue. Uses hprc_pkg.
module hprc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  output logic            push,
  output hprc_pkg::cmd_t  push_data,
  input  logic            q_full
);

  logic [7:0] held [hprc_pkg::HPRC_HELD];
  logic [4:0] byte_count;
  logic [4:0] len;
  logic       accept;
  hprc_pkg::kind_t kind;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len      = (byte_count < hprc_pkg::HPRC_CNT_MAX) ? byte_count + 5'd1
                                                          : hprc_pkg::HPRC_CNT_MAX;

  always_comb begin
    if (len == hprc_pkg::HPRC_LEN_MOUSE) begin
      kind = hprc_pkg::KIND_MOUSE;
    end else if (len == hprc_pkg::HPRC_LEN_PAD) begin
      kind = hprc_pkg::KIND_PAD;
    end else if (len >= hprc_pkg::HPRC_LEN_SMIN && len < hprc_pkg::HPRC_LEN_MOUSE) begin
      kind = hprc_pkg::KIND_SIMPLE;
    end else begin
      kind = hprc_pkg::KIND_NONE;
    end
  end

  // Merge the byte in flight so the command sees the whole report.
  always_comb begin
    push_data.kind = kind;
    push_data.last = in_byte;
    for (int i = 0; i < hprc_pkg::HPRC_HELD; i++) begin
      push_data.b[i] = (byte_count == 5'(i)) ? in_byte : held[i];
    end
  end

  assign push = accept && in_end && (kind != hprc_pkg::KIND_NONE);

  always_ff @(posedge clk) begin
    if (accept && byte_count < 5'(hprc_pkg::HPRC_HELD)) begin
      held[byte_count[2:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= in_end ? 5'd0 : len;
    end
  end

endmodule

// ===== design/hprc_fifo.sv =====
// hprc_fifo: short command queue between the front and back ends.
// Depth and types come from hprc_pkg.
module hprc_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hprc_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output hprc_pkg::cmd_t  pop_data,
  output logic            not_empty
);

  hprc_pkg::cmd_t mem [hprc_pkg::HPRC_QDEPTH];
  logic [hprc_pkg::HPRC_QPTR_W-1:0] wr_ptr;
  logic [hprc_pkg::HPRC_QPTR_W-1:0] rd_ptr;
  logic [hprc_pkg::HPRC_QCNT_W-1:0] count;

  localparam logic [hprc_pkg::HPRC_QPTR_W-1:0] PtrLast =
    hprc_pkg::HPRC_QPTR_W'(hprc_pkg::HPRC_QDEPTH - 1);
  localparam logic [hprc_pkg::HPRC_QCNT_W-1:0] CntFull =
    hprc_pkg::HPRC_QCNT_W'(hprc_pkg::HPRC_QDEPTH);

  assign full      = (count == CntFull);
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && not_empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && not_empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/hprc_back.sv =====
// hprc_back: executes report commands: formats mouse reports, runs the
// trackpad tracker with a two-lane bit-serial divider, and drives the
// output register. Uses hprc_pkg.
module hprc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic [4:0]      move_divisor,
  input  logic            cmd_valid,
  input  hprc_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output hprc_pkg::res_t  out_res,
  output logic            out_last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [4:0] rem;
    logic [7:0] dq;
  } div_t;

  state_t state;

  hprc_pkg::res_t r0, r1;
  logic r0_valid, r1_valid;

  logic [11:0] move_prev_x, move_prev_y, scroll_prev_y;
  logic        move_has_prev, move_active;
  logic        scroll_has_prev, scroll_active;
  logic        pad_button_down;
  logic [6:0]  last_contact_count;

  logic [4:0] rem_x, rem_y;
  logic [7:0] dq_x, dq_y;
  logic       neg_x, neg_y;
  logic [2:0] div_cnt;

  function automatic div_t div_step(input logic [4:0] rem, input logic [7:0] dq,
                                    input logic [4:0] d);
    logic [5:0] trial;
    logic       ge;
    div_t       r;
    trial = {rem, dq[7]};
    ge    = (trial >= {1'b0, d});
    r.rem = ge ? 5'(trial - {1'b0, d}) : trial[4:0];
    r.dq  = {dq[6:0], ge};
    return r;
  endfunction

  // Trackpad decode of the head command.
  logic        click, touch, click_chg, cnt_chg, mhp, shp;
  logic [6:0]  contacts;
  logic [11:0] px, py;
  logic signed [12:0] sdy, mdx, mdy;
  logic [12:0] sdy_mag, mdx_mag, mdy_mag;
  logic        s_in, m_in, scroll_emit, move_go;
  logic [7:0]  s_ext, s_val;
  logic [4:0]  div_eff;
  div_t        nx, ny;
  logic [11:0] qx, qy, fx, fy;
  logic        out_load;

  assign click     = cmd.last[7];
  assign contacts  = cmd.last[6:0];
  assign touch     = cmd.b[0][1];
  assign px        = {cmd.b[2][3:0], cmd.b[1]};
  assign py        = {cmd.b[3], cmd.b[2][7:4]};
  assign click_chg = (click != pad_button_down);
  assign cnt_chg   = (contacts != last_contact_count);
  assign mhp       = cnt_chg ? 1'b0 : move_has_prev;
  assign shp       = cnt_chg ? 1'b0 : scroll_has_prev;

  assign sdy = $signed({1'b0, py}) - $signed({1'b0, scroll_prev_y});
  assign mdx = $signed({1'b0, px}) - $signed({1'b0, move_prev_x});
  assign mdy = $signed({1'b0, py}) - $signed({1'b0, move_prev_y});
  assign sdy_mag = sdy[12] ? 13'(-sdy) : sdy;
  assign mdx_mag = mdx[12] ? 13'(-mdx) : mdx;
  assign mdy_mag = mdy[12] ? 13'(-mdy) : mdy;
  assign s_in = (sdy > hprc_pkg::HPRC_JUMP_LO) && (sdy < hprc_pkg::HPRC_JUMP_HI);
  assign m_in = (mdx > hprc_pkg::HPRC_JUMP_LO) && (mdx < hprc_pkg::HPRC_JUMP_HI) &&
                (mdy > hprc_pkg::HPRC_JUMP_LO) && (mdy < hprc_pkg::HPRC_JUMP_HI);

  // Scroll is the negated dy/8, truncated toward zero.
  assign s_ext = {3'b000, sdy_mag[7:3]};
  assign s_val = sdy[12] ? s_ext : 8'(-s_ext);
  assign scroll_emit = (contacts == hprc_pkg::HPRC_CONTACT_TWO) && touch && shp && s_in &&
                       (s_ext != 8'd0);
  assign move_go = (contacts == hprc_pkg::HPRC_CONTACT_ONE) && touch && mhp && m_in;

  assign div_eff = (move_divisor == 5'd0) ? 5'd1 : move_divisor;
  assign nx = div_step(rem_x, dq_x, div_eff);
  assign ny = div_step(rem_y, dq_y, div_eff);
  assign qx = {4'b0000, dq_x};
  assign qy = {4'b0000, dq_y};
  assign fx = neg_x ? 12'(-qx) : qx;
  assign fy = neg_y ? 12'(-qy) : qy;

  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign out_load = (state == ST_EMIT) && (!out_valid || out_ready) && (r0_valid || r1_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      r0_valid           <= 1'b0;
      r1_valid           <= 1'b0;
      out_valid          <= 1'b0;
      move_prev_x        <= '0;
      move_prev_y        <= '0;
      scroll_prev_y      <= '0;
      move_has_prev      <= 1'b0;
      move_active        <= 1'b0;
      scroll_has_prev    <= 1'b0;
      scroll_active      <= 1'b0;
      pad_button_down    <= 1'b0;
      last_contact_count <= '0;
      div_cnt            <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              hprc_pkg::KIND_MOUSE: begin
                r0.button_bits      <= cmd.b[0];
                r0.delta_x          <= {cmd.b[3][3:0], cmd.b[2]};
                r0.delta_y          <= {cmd.b[4], cmd.b[3][7:4]};
                r0.wheel_vertical   <= cmd.b[5];
                r0.wheel_horizontal <= cmd.b[6];
                r0_valid            <= 1'b1;
                state               <= ST_EMIT;
              end
              hprc_pkg::KIND_SIMPLE: begin
                r0.button_bits      <= {5'b00000, cmd.b[0][2:0]};
                r0.delta_x          <= {{4{cmd.b[1][7]}}, cmd.b[1]};
                r0.delta_y          <= {{4{cmd.b[2][7]}}, cmd.b[2]};
                r0.wheel_vertical   <= cmd.b[3];
                r0.wheel_horizontal <= '0;
                r0_valid            <= 1'b1;
                state               <= ST_EMIT;
              end
              hprc_pkg::KIND_PAD: begin
                r0          <= '{button_bits: {7'b0, click}, default: '0};
                r0_valid    <= click_chg;
                r1          <= '{wheel_vertical: s_val, default: '0};
                r1_valid    <= scroll_emit;
                pad_button_down    <= click;
                last_contact_count <= contacts;
                if (contacts == hprc_pkg::HPRC_CONTACT_TWO) begin
                  move_has_prev   <= mhp;
                  scroll_prev_y   <= py;
                  scroll_has_prev <= touch;
                  scroll_active   <= touch;
                end else if (contacts == hprc_pkg::HPRC_CONTACT_ONE && touch) begin
                  move_prev_x     <= px;
                  move_prev_y     <= py;
                  move_has_prev   <= 1'b1;
                  move_active     <= 1'b1;
                  scroll_has_prev <= shp;
                end else if (contacts == hprc_pkg::HPRC_CONTACT_NONE &&
                             (move_active || scroll_active)) begin
                  move_active     <= 1'b0;
                  move_has_prev   <= 1'b0;
                  scroll_active   <= 1'b0;
                  scroll_has_prev <= 1'b0;
                end else begin
                  move_has_prev   <= mhp;
                  scroll_has_prev <= shp;
                end
                // Load both divider lanes with the deltas' magnitudes.
                dq_x    <= mdx_mag[7:0];
                dq_y    <= mdy_mag[7:0];
                rem_x   <= '0;
                rem_y   <= '0;
                neg_x   <= mdx[12];
                neg_y   <= mdy[12];
                div_cnt <= 3'(hprc_pkg::HPRC_DIV_STEPS - 1);
                if (move_go) begin
                  state <= ST_DIV;
                end else if (click_chg || scroll_emit) begin
                  state <= ST_EMIT;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem_x   <= nx.rem;
          dq_x    <= nx.dq;
          rem_y   <= ny.rem;
          dq_y    <= ny.dq;
          div_cnt <= div_cnt - 3'd1;
          if (div_cnt == 3'd0) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          r1 <= '{button_bits: {7'b0, pad_button_down}, delta_x: fx, delta_y: fy,
                  default: '0};
          if (dq_x != 8'd0 || dq_y != 8'd0) begin
            r1_valid <= 1'b1;
            state    <= ST_EMIT;
          end else if (r0_valid) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (r0_valid) begin
              out_res  <= r0;
              out_last <= !r1_valid;
              r0_valid <= 1'b0;
              if (!r1_valid) begin
                state <= ST_IDLE;
              end
            end else begin
              out_res  <= r1;
              out_last <= 1'b1;
              r1_valid <= 1'b0;
              state    <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !r0_valid && !r1_valid)
    else $error("pending result left in idle");
  a_emit_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> r0_valid || r1_valid)
    else $error("emit state with nothing to send");
  a_second_nonzero: assert property (@(posedge clk) disable iff (rst)
    r1_valid |-> r1.delta_x != 12'd0 || r1.delta_y != 12'd0 || r1.wheel_vertical != 8'd0)
    else $error("empty motion or scroll result queued");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_load && r0_valid && r1_valid |=> !r0_valid && r1_valid && !out_last)
    else $error("result order broken");
`endif

endmodule

// ===== tb/sv/tb_hid_pointer_report_converter_core.sv =====
// Self-checking testbench for hid_pointer_report_converter_core.
// A scoreboard predicts mouse, simple mouse and trackpad results from the accepted
// report bytes under random handshake gaps. Depends on hprc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_hid_pointer_report_converter_core;

  localparam int JUMP_LIMIT  = 150;
  localparam int SCROLL_STEP = 8;
  localparam int SETTLE      = 40;

  typedef struct packed {
    hprc_pkg::res_t res;
    logic fin;
  } pointer_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
  } report_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  hid_pointer_report_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Scoreboard copy of the converter state
  logic [7:0]  held [hprc_pkg::HPRC_HELD];
  logic [4:0]  byte_cnt = '0;
  logic [11:0] mv_px = '0, mv_py = '0, sc_py = '0;
  logic        mv_has = 1'b0, mv_act = 1'b0, sc_has = 1'b0, sc_act = 1'b0;
  logic        pad_down = 1'b0;
  logic [6:0]  seen_contacts = '0;
  logic [4:0]  move_div = 5'd1;

  pointer_result_t expected_reports [$];
  report_byte_t    byte_queue [$];
  int              queued_count = 0;
  int              sent_count = 0;
  int              fail_count = 0;

  function automatic pointer_result_t pointer_result(input logic [7:0] btn,
                                                     input logic [11:0] dx, dy,
                                                     input logic [7:0] wv, wh);
    pointer_result_t r;
    r.res.button_bits      = btn;
    r.res.delta_x          = dx;
    r.res.delta_y          = dy;
    r.res.wheel_vertical   = wv;
    r.res.wheel_horizontal = wh;
    r.fin                  = 1'b0;
    return r;
  endfunction

  // Advance the scoreboard by one accepted byte and queue the results it causes
  function automatic void apply_report_byte(input logic [7:0] b, input logic eor);
    pointer_result_t outs [2];
    int          n;
    logic [4:0]  len;
    logic        click, touch;
    logic [6:0]  contacts;
    logic [11:0] px, py;
    int          dh, dv, sv, dd;
    n = 0;
    if (byte_cnt < hprc_pkg::HPRC_HELD) held[byte_cnt[2:0]] = b;
    len = (byte_cnt < hprc_pkg::HPRC_CNT_MAX) ? byte_cnt + 5'd1 : hprc_pkg::HPRC_CNT_MAX;
    if (!eor) begin
      byte_cnt = len;
      return;
    end
    byte_cnt = '0;
    if (len == hprc_pkg::HPRC_LEN_MOUSE) begin
      outs[n] = pointer_result(held[0], {held[3][3:0], held[2]}, {held[4], held[3][7:4]},
                               held[5], held[6]);
      n++;
    end else if (len == hprc_pkg::HPRC_LEN_PAD) begin
      click    = b[7];
      contacts = b[6:0];
      touch    = held[0][1];
      px       = {held[2][3:0], held[1]};
      py       = {held[3], held[2][7:4]};
      if (click != pad_down) begin
        pad_down = click;
        outs[n]  = pointer_result({7'd0, click}, '0, '0, '0, '0);
        n++;
      end
      if (contacts != seen_contacts) begin
        mv_has        = 1'b0;
        sc_has        = 1'b0;
        seen_contacts = contacts;
      end
      if (contacts == hprc_pkg::HPRC_CONTACT_TWO) begin
        if (touch && sc_has) begin
          dv = int'(py) - int'(sc_py);
          if (dv > -JUMP_LIMIT && dv < JUMP_LIMIT) begin
            sv = -(dv / SCROLL_STEP);
            if (sv != 0) begin
              outs[n] = pointer_result('0, '0, '0, sv[7:0], '0);
              n++;
            end
          end
        end
        sc_py  = py;
        sc_has = touch;
        sc_act = touch;
      end else if (contacts == hprc_pkg::HPRC_CONTACT_ONE && touch) begin
        if (mv_has) begin
          dh = int'(px) - int'(mv_px);
          dv = int'(py) - int'(mv_py);
          if (dh > -JUMP_LIMIT && dh < JUMP_LIMIT && dv > -JUMP_LIMIT && dv < JUMP_LIMIT) begin
            dd = (move_div == 5'd0) ? 1 : int'(move_div);
            dh = dh / dd;
            dv = dv / dd;
            if (dh != 0 || dv != 0) begin
              outs[n] = pointer_result({7'd0, pad_down}, dh[11:0], dv[11:0], '0, '0);
              n++;
            end
          end
        end
        mv_px  = px;
        mv_py  = py;
        mv_has = 1'b1;
        mv_act = 1'b1;
      end else if (contacts == hprc_pkg::HPRC_CONTACT_NONE) begin
        if (mv_act || sc_act) begin
          mv_act = 1'b0;
          mv_has = 1'b0;
          sc_act = 1'b0;
          sc_has = 1'b0;
        end
      end
    end else if (len >= hprc_pkg::HPRC_LEN_SMIN && len < hprc_pkg::HPRC_LEN_MOUSE) begin
      outs[n] = pointer_result(held[0] & 8'h07, {{4{held[1][7]}}, held[1]},
                               {{4{held[2][7]}}, held[2]}, held[3], '0);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      outs[i].fin = (i == n - 1);
      expected_reports.push_back(outs[i]);
    end
  endfunction

  // Sender: bursts of transfers separated by random gaps
  int           burst_left = 0;
  int           gap_left = 0;
  report_byte_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_report_byte(s_tdata, s_tlast);
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          nxt = byte_queue.pop_front();
          s_tdata  <= nxt.data;
          s_tlast  <= nxt.eor;
          s_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches between always ready, light and heavy stalls
  int              rdy_mode = 0;
  int              rdy_left = 0;
  pointer_result_t want, got;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.res = hprc_pkg::res_t'(m_tdata);
        got.fin = m_tlast;
        if (expected_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: tdata=%h tlast=%b", m_tdata, m_tlast);
        end else begin
          want = expected_reports.pop_front();
          if (got.res.button_bits !== want.res.button_bits ||
              got.res.delta_x !== want.res.delta_x ||
              got.res.delta_y !== want.res.delta_y ||
              got.res.wheel_vertical !== want.res.wheel_vertical ||
              got.res.wheel_horizontal !== want.res.wheel_horizontal ||
              got.fin !== want.fin) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("mismatch: exp btn=%h dx=%h dy=%h wv=%h wh=%h last=%b",
                     want.res.button_bits, want.res.delta_x, want.res.delta_y,
                     want.res.wheel_vertical, want.res.wheel_horizontal, want.fin);
              $display(" | got btn=%h dx=%h dy=%h wv=%h wh=%h last=%b",
                       got.res.button_bits, got.res.delta_x, got.res.delta_y,
                       got.res.wheel_vertical, got.res.wheel_horizontal, got.fin);
            end
          end
        end
      end
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 2);
        rdy_left = $urandom_range(20, 200);
      end else begin
        rdy_left--;
      end
      case (rdy_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          m_tready <= ($urandom_range(0, 11) == 0);
        end
      endcase
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic eor);
    report_byte_t item;
    item.data = data;
    item.eor  = eor;
    byte_queue.push_back(item);
    queued_count++;
  endtask

  task automatic push_random_report(input int len);
    for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
  endtask

  task automatic push_pad(input logic [7:0] flags, input logic [11:0] x, y,
                          input logic [7:0] tail);
    push_byte(flags, 1'b0);
    push_byte(x[7:0], 1'b0);
    push_byte({y[3:0], x[11:8]}, 1'b0);
    push_byte(y[11:4], 1'b0);
    for (int i = 0; i < 14; i++) push_byte(8'($urandom), 1'b0);
    push_byte(tail, 1'b1);
  endtask

  // Mostly small steps, sometimes right at the jump limit or beyond it
  function automatic logic [11:0] finger_step();
    int d;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: d = -JUMP_LIMIT;
          1: d = -JUMP_LIMIT + 1;
          2: d = JUMP_LIMIT - 1;
          default: d = JUMP_LIMIT;
        endcase
      end
      1: begin
        d = $urandom_range(0, 400) - 200;
      end
      default: begin
        d = $urandom_range(0, 60) - 30;
      end
    endcase
    return d[11:0];
  endfunction

  // One gesture: a run of trackpad reports with the same contact count, at times followed by a no-contact report
  task automatic push_finger_run(input logic [6:0] contacts);
    logic [11:0] x, y;
    logic [7:0]  flags;
    logic        click;
    int          steps;
    x     = 12'($urandom);
    y     = 12'($urandom);
    click = 1'($urandom_range(0, 1));
    steps = $urandom_range(2, 8);
    for (int i = 0; i < steps; i++) begin
      flags    = 8'($urandom);
      flags[1] = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 5) == 0) click = ~click;
      push_pad(flags, x, y, {click, contacts});
      x = x + finger_step();
      y = y + finger_step();
    end
    if ($urandom_range(0, 1) == 1) begin
      push_pad(8'($urandom), 12'($urandom), 12'($urandom),
               {click, hprc_pkg::HPRC_CONTACT_NONE});
    end
  endtask

  task automatic push_random_traffic(input int budget);
    int start;
    start = queued_count;
    while (queued_count - start < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: push_finger_run(hprc_pkg::HPRC_CONTACT_ONE);
        4, 5:       push_finger_run(hprc_pkg::HPRC_CONTACT_TWO);
        6:          push_random_report($urandom_range(0, 1) ? 7 : $urandom_range(4, 6));
        7: begin
          case ($urandom_range(0, 2))
            0:       push_random_report($urandom_range(1, 3));
            1:       push_random_report($urandom_range(8, 18));
            default: push_random_report($urandom_range(20, 40));
          endcase
        end
        8:          push_random_report(int'(hprc_pkg::HPRC_LEN_PAD));
        default:    push_pad(8'($urandom), 12'($urandom), 12'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // Hold off until every byte is taken and every result has come back
  task automatic wait_idle();
    int guard;
    guard = 0;
    while ((sent_count != queued_count || expected_reports.size() != 0) && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [4:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    move_div  = value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  logic [4:0] divisor_plan [6] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd3, 5'd7};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_divisor(5'd1);

    // full mouse at both ends of the ranges, simple mice, a one-byte report
    for (int i = 0; i < 7; i++) push_byte(8'hFF, i == 6);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hF8, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h07, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h81, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    push_byte(8'h00, 1'b1);
    wait_idle();

    foreach (divisor_plan[i]) begin
      write_divisor(divisor_plan[i]);
      push_random_traffic(230);
      wait_idle();
    end

    if (fail_count == 0 && expected_reports.size() == 0 && sent_count == queued_count)
      $display("tb_hid_pointer_report_converter_core: PASS");
    else
      $display("tb_hid_pointer_report_converter_core: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_hid_pointer_report_converter_core: FAIL");
    $finish;
  end

endmodule
